@@ hdl/cfseq_pkg.sv @@
// Shared types, constants and helper functions for the clock fan-out init sequencer.
// No dependencies; every other file but the two channel interfaces imports this package.
package cfseq_pkg;

  localparam int unsigned NUM_WRITES  = 30;
  localparam int unsigned STEP_W      = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_BOARD_VARIANT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AUX_DIVISOR   = 2'd1;

  localparam logic [1:0] VARIANT_PROTO = 2'd0;
  localparam logic [1:0] VARIANT_PMT   = 2'd1;
  localparam logic [1:0] VARIANT_V1A   = 2'd2;

  localparam logic [1:0] BOARD_VARIANT_RESET = VARIANT_V1A;
  localparam logic [7:0] AUX_DIVISOR_RESET   = 8'd25;

  localparam logic [7:0] PMT_FORCE  = 8'h60;
  localparam logic [7:0] PMT_TRIM   = 8'h61;
  localparam logic [7:0] V1A_FORCE  = 8'h41;
  localparam logic [7:0] V1A_TRIM   = 8'h67;
  localparam logic [7:0] PROTO_MASK = 8'h01;

  localparam logic [5:0] DIV_SAT = 6'd32;

  typedef struct packed {
    logic [7:0] mask;
    logic       div_bypass;
    logic [7:0] div_code;
    logic       aux_bypass;
    logic [7:0] aux_code;
  } job_t;

  typedef struct packed {
    logic       bypass;
    logic [7:0] code;
  } div_word_t;

  function automatic logic [7:0] trim_mask(logic [1:0] variant, logic [7:0] m);
    logic [7:0] r;
    r = 8'h00;
    case (variant)
      VARIANT_PROTO: r = (m != 8'h00) ? PROTO_MASK : 8'h00;
      VARIANT_PMT:   r = (m != 8'h00) ? ((m | PMT_FORCE) & PMT_TRIM) : 8'h00;
      default:       r = (m != 8'h00) ? ((m | V1A_FORCE) & V1A_TRIM) : 8'h00;
    endcase
    return r;
  endfunction

  function automatic div_word_t divider_code(logic [7:0] d);
    div_word_t  w;
    logic [5:0] ds;
    logic [5:0] dp1;
    logic [4:0] hi;
    logic [4:0] lo;
    ds  = (d > 8'(DIV_SAT)) ? DIV_SAT : d[5:0];
    dp1 = ds + 6'd1;
    hi  = ds[5:1] - 5'd1;
    lo  = dp1[5:1] - 5'd1;
    if (d <= 8'd1) begin
      w.bypass = 1'b1;
      w.code   = 8'h00;
    end else begin
      w.bypass = 1'b0;
      w.code   = {hi[3:0], lo[3:0]};
    end
    return w;
  endfunction

endpackage

@@ hdl/cfseq_req_if.sv @@
// Request channel: channel enable mask and divisor with valid/ready.
// Depends on nothing.
interface cfseq_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] channel_enable;
  logic [7:0] divisor;

  modport source (output valid, output channel_enable, output divisor, input ready);
  modport sink   (input valid, input channel_enable, input divisor, output ready);
endinterface

@@ hdl/cfseq_wr_if.sv @@
// Register write channel: address, data byte and last mark with valid/ready.
// Depends on nothing.
interface cfseq_wr_if;
  logic       valid;
  logic       ready;
  logic [7:0] reg_address;
  logic [7:0] reg_data;
  logic       last;

  modport source (output valid, output reg_address, output reg_data, output last,
                  input ready);
  modport sink   (input valid, input reg_address, input reg_data, input last,
                  output ready);
endinterface

@@ hdl/cfseq_front.sv @@
// Front end: configuration registers, request acceptance, mask trimming and divider coding.
// Depends on cfseq_pkg and cfseq_req_if.
module cfseq_front
  import cfseq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cfseq_req_if.sink             req_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output job_t                  push_job_o
);

  logic [1:0] variant_q;
  logic [7:0] aux_div_q;
  div_word_t  div_w;
  div_word_t  aux_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= BOARD_VARIANT_RESET;
      aux_div_q <= AUX_DIVISOR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BOARD_VARIANT: variant_q <= cfg_data_i[1:0];
        CFG_AUX_DIVISOR:   aux_div_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    div_w                 = divider_code(req_i.divisor);
    aux_w                 = divider_code(aux_div_q);
    push_job_o.mask       = trim_mask(variant_q, req_i.channel_enable);
    push_job_o.div_bypass = div_w.bypass;
    push_job_o.div_code   = div_w.code;
    push_job_o.aux_bypass = aux_w.bypass;
    push_job_o.aux_code   = aux_w.code;
  end

  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

endmodule

@@ hdl/cfseq_queue.sv @@
// Two-entry job queue between the front end and the write generator.
// Depends on cfseq_pkg.
module cfseq_queue
  import cfseq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_job_i,
  output logic head_valid_o,
  output job_t head_job_o,
  input  logic pop_i
);

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic [QCNT_W-1:0] count_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    count_d = count_q;
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_job_i;
  end

endmodule

@@ hdl/cfseq_back.sv @@
// Back end: walks the thirty-write sequence for the head job into an output register.
// Depends on cfseq_pkg and cfseq_wr_if.
module cfseq_back
  import cfseq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  job_t        head_job_i,
  output logic        pop_o,
  cfseq_wr_if.source  wr_o
);

  localparam logic [STEP_W-1:0] STEP_LVDS_FIRST = 5'd4;
  localparam logic [STEP_W-1:0] STEP_DIV_FIRST  = 5'd8;
  localparam logic [STEP_W-1:0] STEP_CLK_IN     = 5'd24;
  localparam logic [STEP_W-1:0] STEP_STATUS     = 5'd25;
  localparam logic [STEP_W-1:0] STEP_SYNC_ON    = 5'd26;
  localparam logic [STEP_W-1:0] STEP_EXEC_ON    = 5'd27;
  localparam logic [STEP_W-1:0] STEP_SYNC_OFF   = 5'd28;
  localparam logic [STEP_W-1:0] STEP_LAST       = STEP_W'(NUM_WRITES - 1);

  logic [STEP_W-1:0] step_q;
  logic [STEP_W-1:0] step_d;
  logic              valid_q;
  logic              valid_d;
  logic [7:0]        addr_q;
  logic [7:0]        data_q;
  logic              last_q;
  logic [7:0]        addr_d;
  logic [7:0]        data_d;
  logic              advance;
  logic [STEP_W-1:0] rel;
  logic [2:0]        chan;
  logic              chan_en;
  logic              is_aux;
  logic              bypass;
  logic [7:0]        code;
  logic              any_en;

  assign advance = head_valid_i && (!valid_q || wr_o.ready);
  assign pop_o   = advance && (step_q == STEP_LAST);
  assign rel     = step_q - STEP_DIV_FIRST;
  assign chan    = rel[3:1];
  assign chan_en = head_job_i.mask[chan];
  assign is_aux  = (chan == 3'd6);
  assign bypass  = !chan_en || (is_aux ? head_job_i.aux_bypass : head_job_i.div_bypass);
  assign code    = is_aux ? head_job_i.aux_code : head_job_i.div_code;
  assign any_en  = (head_job_i.mask != 8'h00);

  always_comb begin
    addr_d = 8'h00;
    data_d = 8'h00;
    if (step_q < STEP_LVDS_FIRST) begin
      addr_d = 8'h3C + {3'b000, step_q};
      data_d = head_job_i.mask[step_q[2:0]] ? 8'h08 : 8'h0A;
    end else if (step_q < STEP_DIV_FIRST) begin
      addr_d = 8'h3C + {3'b000, step_q};
      data_d = head_job_i.mask[step_q[2:0]] ? 8'h02 : 8'h03;
    end else if (step_q < STEP_CLK_IN) begin
      addr_d = 8'h48 + {4'h0, rel[3:0]};
      if (rel[0]) begin
        data_d = bypass ? 8'h80 : 8'h00;
      end else begin
        data_d = bypass ? 8'h00 : code;
      end
    end else begin
      case (step_q)
        STEP_CLK_IN: begin
          addr_d = 8'h45;
          data_d = any_en ? 8'h1D : 8'h3F;
        end
        STEP_STATUS: begin
          addr_d = 8'h08;
          data_d = any_en ? 8'h00 : 8'h2C;
        end
        STEP_SYNC_ON: begin
          addr_d = 8'h58;
          data_d = 8'h04;
        end
        STEP_EXEC_ON: begin
          addr_d = 8'h5A;
          data_d = 8'h01;
        end
        STEP_SYNC_OFF: begin
          addr_d = 8'h58;
          data_d = 8'h00;
        end
        default: begin
          addr_d = 8'h5A;
          data_d = 8'h01;
        end
      endcase
    end
  end

  always_comb begin
    step_d  = step_q;
    valid_d = valid_q;
    if (advance) begin
      step_d  = (step_q == STEP_LAST) ? '0 : step_q + 1'b1;
      valid_d = 1'b1;
    end else if (wr_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      addr_q <= addr_d;
      data_q <= data_d;
      last_q <= (step_q == STEP_LAST);
    end
  end

  assign wr_o.valid       = valid_q;
  assign wr_o.reg_address = addr_q;
  assign wr_o.reg_data    = data_q;
  assign wr_o.last        = last_q;

endmodule

@@ hdl/clock_fanout_init_sequencer_top.sv @@
// Top level of the clock fan-out init sequencer: front end, job queue, write generator.
// Depends on cfseq_pkg, cfseq_req_if, cfseq_wr_if, cfseq_front, cfseq_queue, cfseq_back.
//
//   channel   dir  handshake         payload
//   req_i     in   valid/ready       channel_enable[7:0], divisor[7:0]
//   wr_o      out  valid/ready       reg_address[7:0], reg_data[7:0], last
//   cfg       in   cfg_we_i          cfg_index_i[1:0], cfg_data_i[7:0]
//
// Each request yields 30 writes from the write generator's step counter, one per cycle
// unless wr_o stalls. Accepted requests pass through the job queue to the output register.
// The job queue holds two requests, the one being walked among them.
// Reset clears the queue, step counter and output valid; no clearing pass.
// A stalled wr_o holds the generator; req_i stalls only when the queue is full.
module clock_fanout_init_sequencer_top
  import cfseq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cfseq_req_if.sink             req_i,
  cfseq_wr_if.source            wr_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic head_valid;
  job_t head_job;
  logic pop;

  cfseq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  cfseq_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .head_valid_o (head_valid),
    .head_job_o   (head_job),
    .pop_i        (pop)
  );

  cfseq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .wr_o         (wr_o)
  );

endmodule

@@ hdl/cfseq_checker.sv @@
// Port-level checks for the clock fan-out init sequencer, bound to the top level.
// Depends on cfseq_pkg.
module cfseq_checker
  import cfseq_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       wr_valid_i,
  input logic       wr_ready_i,
  input logic [7:0] wr_address_i,
  input logic [7:0] wr_data_i,
  input logic       wr_last_i
);

  logic [STEP_W-1:0] seen_q;
  logic [1:0]        pending_q;
  logic              req_xfer;
  logic              wr_xfer;
  logic              seq_done;

  assign req_xfer = req_valid_i && req_ready_i;
  assign wr_xfer  = wr_valid_i && wr_ready_i;
  assign seq_done = wr_xfer && wr_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      pending_q <= '0;
    end else begin
      if (wr_xfer) seen_q <= wr_last_i ? '0 : seen_q + 1'b1;
      pending_q <= pending_q + {1'b0, req_xfer} - {1'b0, seq_done};
    end
  end

  a_last_on_thirtieth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_xfer |-> (wr_last_i == (seen_q == STEP_W'(NUM_WRITES - 1))))
    else $error("last mark out of place in write sequence");

  a_no_write_without_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i |-> (pending_q != 2'd0))
    else $error("write shown with no request outstanding");

  a_pending_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |-> (pending_q != 2'd3))
    else $error("request taken beyond queue capacity");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_valid_i && !wr_ready_i) |=>
      (wr_valid_i && $stable(wr_address_i) && $stable(wr_data_i) && $stable(wr_last_i)))
    else $error("stalled write changed");

endmodule

bind clock_fanout_init_sequencer_top cfseq_checker u_cfseq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .wr_valid_i   (wr_o.valid),
  .wr_ready_i   (wr_o.ready),
  .wr_address_i (wr_o.reg_address),
  .wr_data_i    (wr_o.reg_data),
  .wr_last_i    (wr_o.last)
);

@@ verif/cfseq_write_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the clock fan-out init sequencer: expands each accepted request into its
// thirty register writes and compares them, in order, with the write channel.
// Depends on cfseq_pkg, cfseq_req_if and cfseq_wr_if.
module cfseq_write_checker
  import cfseq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cfseq_req_if                  req_i,
  cfseq_wr_if                   wr_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatch_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } reg_write_t;

  logic [1:0] variant_q;
  logic [7:0] aux_div_q;
  reg_write_t pending_writes[$];
  int         writes_seen;

  initial begin
    mismatch_count_o = 0;
    writes_seen      = 0;
  end

  function automatic logic [7:0] board_mask(logic [1:0] variant, logic [7:0] m);
    if (m == 8'h00) return 8'h00;
    case (variant)
      VARIANT_PROTO: return PROTO_MASK;
      VARIANT_PMT:   return (m | PMT_FORCE) & PMT_TRIM;
      default:       return (m | V1A_FORCE) & V1A_TRIM;
    endcase
  endfunction

  // upper byte is the first divider word, lower byte the second
  function automatic logic [15:0] divider_words(logic [7:0] d);
    int unsigned ds;
    ds = (d > 8'd32) ? 32 : int'(d);
    if (d <= 8'd1) return {8'h00, 8'h80};
    return {8'(((ds / 2 - 1) << 4) + ((ds + 1) / 2 - 1)), 8'h00};
  endfunction

  function automatic void expand_request(logic [7:0] req_mask, logic [7:0] req_div);
    logic [7:0]  m;
    logic [7:0]  d;
    logic [15:0] words;
    logic [7:0]  addr [NUM_WRITES];
    logic [7:0]  data [NUM_WRITES];
    reg_write_t  w;
    m = board_mask(variant_q, req_mask);
    for (int n = 0; n < 8; n++) begin
      addr[n] = 8'h3C + 8'(n);
      if (n < 4) data[n] = m[n] ? 8'h08 : 8'h0A;
      else       data[n] = m[n] ? 8'h02 : 8'h03;
    end
    for (int n = 0; n < 8; n++) begin
      d = !m[n] ? 8'h00 : (n == 6) ? aux_div_q : req_div;
      words = divider_words(d);
      addr[8 + 2*n] = 8'h48 + 8'(2*n);
      data[8 + 2*n] = words[15:8];
      addr[9 + 2*n] = 8'h49 + 8'(2*n);
      data[9 + 2*n] = words[7:0];
    end
    addr[24] = 8'h45; data[24] = (m != 8'h00) ? 8'h1D : 8'h3F;
    addr[25] = 8'h08; data[25] = (m != 8'h00) ? 8'h00 : 8'h2C;
    addr[26] = 8'h58; data[26] = 8'h04;
    addr[27] = 8'h5A; data[27] = 8'h01;
    addr[28] = 8'h58; data[28] = 8'h00;
    addr[29] = 8'h5A; data[29] = 8'h01;
    for (int k = 0; k < NUM_WRITES; k++) begin
      w.addr = addr[k];
      w.data = data[k];
      w.last = (k == NUM_WRITES - 1);
      pending_writes.push_back(w);
    end
  endfunction

  task automatic note_failure(input string what);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("[%0t] write %0d: %s", $time, writes_seen, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reg_write_t want;
    if (!rst_ni) begin
      variant_q <= BOARD_VARIANT_RESET;
      aux_div_q <= AUX_DIVISOR_RESET;
      pending_writes.delete();
      pending_o <= 0;
    end else begin
      if (req_i.valid && req_i.ready) expand_request(req_i.channel_enable, req_i.divisor);
      if (wr_i.valid && wr_i.ready) begin
        if (pending_writes.size() == 0) begin
          note_failure($sformatf("unexpected transfer addr %h data %h last %b",
                                 wr_i.reg_address, wr_i.reg_data, wr_i.last));
        end else begin
          want = pending_writes.pop_front();
          if (wr_i.reg_address !== want.addr || wr_i.reg_data !== want.data ||
              wr_i.last !== want.last)
            note_failure($sformatf("expected addr %h data %h last %b, got %h %h %b",
                                   want.addr, want.data, want.last,
                                   wr_i.reg_address, wr_i.reg_data, wr_i.last));
        end
        writes_seen++;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BOARD_VARIANT: variant_q <= cfg_data_i[1:0];
          CFG_AUX_DIVISOR:   aux_div_q <= cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= pending_writes.size();
    end
  end

endmodule

@@ verif/clock_fanout_init_sequencer_top_tb.sv @@
`timescale 1ns / 100ps
// Test bench top for the clock fan-out init sequencer: drives requests and register
// settings with random idling, and gives the verdict from cfseq_write_checker.
// Depends on cfseq_pkg, the channel interfaces, the sequencer top and the checker.
module clock_fanout_init_sequencer_top_tb;
  import cfseq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int          NUM_PHASES  = 8;
  localparam int          STEADY_PHASE = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 2'd3;
  localparam logic [1:0]           VARIANT_SPARE = 2'd3;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  steady      = 1'b0;
  int unsigned           cycle_count = 0;
  int                    mismatch_count;
  int                    pending_count;

  logic [1:0] phase_variant [NUM_PHASES] = '{VARIANT_PROTO, VARIANT_PMT, VARIANT_SPARE,
                                             VARIANT_V1A, VARIANT_PMT, VARIANT_SPARE,
                                             VARIANT_V1A, VARIANT_PROTO};
  logic [7:0] phase_aux [NUM_PHASES] = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd33, 8'd255,
                                         8'd0, 8'd32};

  cfseq_req_if req ();
  cfseq_wr_if  wr ();

  clock_fanout_init_sequencer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .wr_o        (wr),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  cfseq_write_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .wr_i             (wr),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    wr.ready <= steady || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** clock_fanout_init_sequencer_top: FAILED **");
      $finish;
    end
  end

  task automatic send_request(input logic [7:0] mask, input logic [7:0] div);
    if (!steady && $urandom_range(0, 99) < 8) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
    req.valid          <= 1'b1;
    req.channel_enable <= mask;
    req.divisor        <= div;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [7:0] mask;
    logic [7:0] div;
    mask = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom);
    case ($urandom_range(0, 3))
      0:       div = 8'($urandom_range(0, 3));
      1:       div = 8'($urandom_range(0, 40));
      default: div = 8'($urandom);
    endcase
    send_request(mask, div);
  endtask

  // drop valid and hold until every expected write has gone out
  task automatic drain();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
  endtask

  task automatic program_board(input logic [1:0] variant, input logic [7:0] aux);
    write_reg(CFG_SPARE_LO, 8'($urandom));
    write_reg(CFG_BOARD_VARIANT, {6'($urandom), variant});
    write_reg(CFG_AUX_DIVISOR, aux);
    write_reg(CFG_SPARE_HI, 8'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    req.valid          = 1'b0;
    req.channel_enable = 8'h00;
    req.divisor        = 8'h00;
    wr.ready           = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(8'h00, 8'h00);
    send_request(8'h00, 8'hFF);
    send_request(8'hFF, 8'hFF);
    send_request(8'hFF, 8'd33);
    send_request(8'hFF, 8'd32);
    send_request(8'hFF, 8'd31);
    send_request(8'hFF, 8'd3);
    send_request(8'hFF, 8'd2);
    send_request(8'hFF, 8'd1);
    for (int n = 0; n < 8; n++) send_request(8'h01 << n, 8'(4 * n + 2));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_board(phase_variant[p], phase_aux[p]);
      steady <= (p == STEADY_PHASE);
      repeat (27) send_random();
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("** clock_fanout_init_sequencer_top: PASSED **");
    end else begin
      $display("** clock_fanout_init_sequencer_top: FAILED **");
    end
    $finish;
  end

endmodule
